// ===== rtl/page_bump_allocator_with_free_bitmap_macros.svh =====
// Assertion macros used by the page allocator checker.
`ifndef PAGE_BUMP_ALLOCATOR_WITH_FREE_BITMAP_MACROS_SVH
`define PAGE_BUMP_ALLOCATOR_WITH_FREE_BITMAP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PGA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PGA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pgalloc_pkg.sv =====
// Shared constants, codes and control/status structs of the page allocator.
`timescale 1ns / 1ps
package pgalloc_pkg;

	localparam int PAGE_W    = 13;
	localparam int IDX_W     = 12;
	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = 64;
	localparam int WIDX_W    = 6;
	localparam int BIT_W     = 6;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 3;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;
	localparam int CNT_LSB   = 0;
	localparam int IDX_LSB   = PAGE_W;

	localparam logic [PAGE_W-1:0] POOL_PAGES = 13'd4096;

	localparam logic [FUNC_W-1:0] FN_ALLOC    = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE     = 2'd1;
	localparam logic [FUNC_W-1:0] FN_ROLLBACK = 2'd2;

	localparam logic [STAT_W-1:0] ST_GRANTED     = 3'd0;
	localparam logic [STAT_W-1:0] ST_FALLBACK    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FREED       = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_IN_POOL = 3'd3;
	localparam logic [STAT_W-1:0] ST_ROLLED_BACK = 3'd4;

	typedef logic [WORD_BITS-1:0] word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic setup;     // decode request, set pointer/range/result
		logic mark_wr;   // OR mask into current word, advance
		logic rb_clear;  // drop all-ones word during rollback
		logic rb_latch;  // hold word with a zero bit for bit search
		logic rb_find;   // trim word, move pointer
		logic out_load;  // move pending result to output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_mark;
		logic need_scan;
		logic mark_last;
		logic all_ones;
		logic word_first;
	} sts_t;

endpackage

// ===== rtl/pgalloc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pgalloc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/pgalloc_ctrl.sv =====
// Controller state machine of the page allocator.
`timescale 1ns / 1ps
module pgalloc_ctrl import pgalloc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECODE  = 3'd1;
	localparam logic [2:0] S_MK_RD   = 3'd2;
	localparam logic [2:0] S_MK_WR   = 3'd3;
	localparam logic [2:0] S_RB_RD   = 3'd4;
	localparam logic [2:0] S_RB_EVAL = 3'd5;
	localparam logic [2:0] S_RB_FIND = 3'd6;
	localparam logic [2:0] S_FINISH  = 3'd7;

	logic [2:0] state_q, state_nxt;
	logic       out_full_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.setup = 1'b1;
				if (sts.need_mark) begin
					state_nxt = S_MK_RD;
				end else if (sts.need_scan) begin
					state_nxt = S_RB_RD;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_MK_RD: begin
				state_nxt = S_MK_WR;
			end
			S_MK_WR: begin
				cmd.mark_wr = 1'b1;
				state_nxt   = sts.mark_last ? S_FINISH : S_MK_RD;
			end
			S_RB_RD: begin
				state_nxt = S_RB_EVAL;
			end
			S_RB_EVAL: begin
				if (sts.all_ones) begin
					cmd.rb_clear = 1'b1;
					state_nxt    = sts.word_first ? S_FINISH : S_RB_RD;
				end else begin
					cmd.rb_latch = 1'b1;
					state_nxt    = S_RB_FIND;
				end
			end
			S_RB_FIND: begin
				cmd.rb_find = 1'b1;
				state_nxt   = S_FINISH;
			end
			S_FINISH: begin
				if (!out_full_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_full_q <= 1'b1;
			end else if (m_tready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_full_q;

endmodule

// ===== rtl/pgalloc_dp.sv =====
// Datapath of the page allocator: pointer, page count, freed bitmap and result.
`timescale 1ns / 1ps
module pgalloc_dp import pgalloc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [PAGE_W-1:0]    cfg_wdata,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [FUNC_W-1:0]    s_tuser,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [STAT_W-1:0]    m_tuser
);

	// highest set bit of a byte
	function automatic logic [2:0] top8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (v[k]) begin
				r = 3'(k);
			end
		end
		return r;
	endfunction

	localparam word_t ALL_ONES = {WORD_BITS{1'b1}};

	logic [PAGE_W-1:0]    page_count_q, bump_q;
	logic [MAP_WORDS-1:0] valid_q;
	logic [FUNC_W-1:0]    func_q;
	logic [PAGE_W-1:0]    count_q;
	logic [IDX_W-1:0]     start_q;
	logic [IDX_W-1:0]     lo_q, hm1_q;
	logic [WIDX_W-1:0]    wi_q;
	logic                 fill_en_q;
	logic [BIT_W-1:0]     fill_off_q;
	word_t                word_q;
	logic [2:0]           byte_q;
	logic [PAGE_W-1:0]    res_page_q, out_page_q;
	logic [STAT_W-1:0]    res_status_q, out_status_q;

	logic [PAGE_W-1:0] pc, limit, fend;
	logic [PAGE_W:0]   room, fsum;
	logic              fit, free_in, free_some, fall_some, b_zero;
	logic [WIDX_W:0]   top_word;
	word_t             ram_rdata, rd_word, mark_mask, fill_mask, ev_word, inv_word;
	word_t             keep_mask, new_word, ram_wdata;
	logic [BIT_W-1:0]  lo_bit, hi_bit, top_pos;
	logic [7:0]        byte_nz, inv_byte;
	logic [2:0]        byte_idx;
	logic [WIDX_W:0]   pos;
	logic [PAGE_W-1:0] rb_page;
	logic              ram_we;

	// usable pages and request decode
	assign pc        = (page_count_q > POOL_PAGES) ? POOL_PAGES : page_count_q;
	assign limit     = (bump_q < pc) ? bump_q : pc;
	assign room      = {1'b0, pc} - {1'b0, bump_q};
	assign fit       = !room[PAGE_W] && (count_q <= room[PAGE_W-1:0]);
	assign fall_some = (bump_q < pc);
	assign free_in   = ({1'b0, start_q} < pc);
	assign fsum      = {2'b00, start_q} + {1'b0, count_q};
	assign fend      = (fsum > {1'b0, limit}) ? limit : fsum[PAGE_W-1:0];
	assign free_some = (fend > {1'b0, start_q});
	assign b_zero    = (limit == '0);
	assign top_word  = limit[PAGE_W-1:BIT_W] - 7'd1;

	// word as stored; a word never written since reset reads as zero
	assign rd_word = valid_q[wi_q] ? ram_rdata : '0;

	// run mask for marking
	assign lo_bit    = (wi_q == lo_q[IDX_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
	assign hi_bit    = (wi_q == hm1_q[IDX_W-1:BIT_W]) ? hm1_q[BIT_W-1:0] : '1;
	assign mark_mask = (ALL_ONES << lo_bit) & (ALL_ONES >> (6'd63 - hi_bit));

	// rollback evaluate: top word gets filled above the pointer
	assign fill_mask = fill_en_q ? (ALL_ONES << fill_off_q) : '0;
	assign ev_word   = rd_word | fill_mask;
	assign inv_word  = ~ev_word;
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			byte_nz[k] = |inv_word[8*k +: 8];
		end
	end
	assign byte_idx = top8(byte_nz);

	// rollback find: highest zero bit inside the chosen byte
	assign inv_byte  = ~word_q[{byte_q, 3'b000} +: 8];
	assign top_pos   = {byte_q, top8(inv_byte)};
	assign keep_mask = ALL_ONES >> (6'd63 - top_pos);
	assign new_word  = word_q & keep_mask;
	assign pos       = {1'b0, top_pos} + 7'd1;
	assign rb_page   = {1'b0, wi_q, 6'b000000} + {6'b000000, pos};

	assign ram_we    = cmd.mark_wr | cmd.rb_find;
	assign ram_wdata = cmd.rb_find ? new_word : (rd_word | mark_mask);

	pgalloc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wi_q),
		.wdata(ram_wdata),
		.raddr(wi_q),
		.rdata(ram_rdata)
	);

	assign sts.need_mark  = ((func_q == FN_ALLOC) && !fit && fall_some) ||
	                        ((func_q == FN_FREE) && free_in && free_some);
	assign sts.need_scan  = (func_q == FN_ROLLBACK) && !b_zero;
	assign sts.mark_last  = (wi_q == hm1_q[IDX_W-1:BIT_W]);
	assign sts.all_ones   = &ev_word;
	assign sts.word_first = (wi_q == '0);

	// control state: config, pointer, per-word valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= POOL_PAGES;
			bump_q       <= '0;
			valid_q      <= '0;
		end else begin
			if (cfg_we) begin
				page_count_q <= cfg_wdata;
			end
			if (cmd.setup) begin
				case (func_q)
					FN_ALLOC: begin
						bump_q <= fit ? bump_q + count_q : pc;
					end
					FN_ROLLBACK: begin
						if (b_zero) begin
							bump_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (ram_we) begin
				valid_q[wi_q] <= 1'b1;
			end
			if (cmd.rb_clear) begin
				valid_q[wi_q] <= 1'b0;
				if (wi_q == '0) begin
					bump_q <= '0;
				end
			end
			if (cmd.rb_find) begin
				bump_q <= rb_page;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= s_tuser;
			count_q <= s_tdata[CNT_LSB +: PAGE_W];
			start_q <= s_tdata[IDX_LSB +: IDX_W];
		end
		if (cmd.setup) begin
			case (func_q)
				FN_ALLOC: begin
					if (fit) begin
						res_page_q   <= bump_q;
						res_status_q <= ST_GRANTED;
					end else begin
						res_page_q   <= '0;
						res_status_q <= ST_FALLBACK;
						lo_q         <= bump_q[IDX_W-1:0];
						hm1_q        <= 12'(pc - 13'd1);
						wi_q         <= bump_q[IDX_W-1:BIT_W];
					end
				end
				FN_FREE: begin
					res_page_q   <= '0;
					res_status_q <= free_in ? ST_FREED : ST_NOT_IN_POOL;
					lo_q         <= start_q;
					hm1_q        <= 12'(fend - 13'd1);
					wi_q         <= start_q[IDX_W-1:BIT_W];
				end
				FN_ROLLBACK: begin
					res_page_q   <= '0;
					res_status_q <= ST_ROLLED_BACK;
					fill_en_q    <= (limit[BIT_W-1:0] != '0);
					fill_off_q   <= limit[BIT_W-1:0];
					wi_q         <= (limit[BIT_W-1:0] != '0) ?
					                limit[IDX_W-1:BIT_W] : top_word[WIDX_W-1:0];
				end
				default: begin
					res_page_q   <= '0;
					res_status_q <= ST_NOT_IN_POOL;
				end
			endcase
		end
		if (cmd.mark_wr && !sts.mark_last) begin
			wi_q <= wi_q + 6'd1;
		end
		if (cmd.rb_clear) begin
			fill_en_q <= 1'b0;
			if (wi_q != '0) begin
				wi_q <= wi_q - 6'd1;
			end
		end
		if (cmd.rb_latch) begin
			word_q    <= ev_word;
			byte_q    <= byte_idx;
			fill_en_q <= 1'b0;
		end
		if (cmd.rb_find) begin
			res_page_q <= rb_page;
		end
		if (cmd.out_load) begin
			out_page_q   <= res_page_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tdata = {{(M_TDATA_W-PAGE_W){1'b0}}, out_page_q};
	assign m_tuser = out_status_q;

endmodule

// ===== rtl/page_bump_allocator_with_free_bitmap.sv =====
// Top level of the page allocator: bump pointer plus freed-page bitmap.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tuser: func; tdata: count, page_index
//  m_*      | out | m_tvalid/m_tready  | tuser: status; tdata: result_page
//  cfg_*    | in  | cfg_we             | page_count, no read-back
//
// Steps: allocate grant, no-op and out-of-pool free go accept, decode, finish.
//   Marking (fallback tail or free run): a registered read and a write per word.
//   Rollback reads and evaluates words downward, dropping all-ones words by
//   valid bit, then trims and writes back the word it stops in.
// Reset: pointer 0, page_count 4096; bitmap words carry valid bits, so the
//   map reads as zero right after reset with no clearing pass.
// Stalls: one output register; a new beat is taken while a result waits,
//   and the next result is held back until m_tready frees that register.
`timescale 1ns / 1ps
module page_bump_allocator_with_free_bitmap import pgalloc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [PAGE_W-1:0]    cfg_wdata,  // page_count
	// request stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,    // [12:0] count, [24:13] page_index, rest 0
	input  logic [FUNC_W-1:0]    s_tuser,    // [1:0] func
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,    // [12:0] result_page, rest 0
	output logic [STAT_W-1:0]    m_tuser     // [2:0] status
);

	cmd_t cmd;
	sts_t sts;

	// sequencing: accept, decode, walk bitmap words, hand off result
	pgalloc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// pointer, page count, bitmap RAM and result registers
	pgalloc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/pgalloc_chk.sv =====
// Port-level checker of the page allocator, bound to the top level.
`timescale 1ns / 1ps
`include "page_bump_allocator_with_free_bitmap_macros.svh"
module pgalloc_chk import pgalloc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STAT_W-1:0]    m_tuser
);

	logic s_beat, m_wait, m_nopage;

	assign s_beat   = s_tvalid && s_tready;
	assign m_wait   = m_tvalid && !m_tready;
	assign m_nopage = m_tvalid && (m_tuser != ST_GRANTED) && (m_tuser != ST_ROLLED_BACK);

	`PGA_ASSERT_NEXT(a_out_hold, m_wait, m_tvalid && $stable({m_tdata, m_tuser}), "beat moved")
	`PGA_ASSERT_NEXT(a_one_at_a_time, s_beat, !s_tready, "request taken while busy")
	`PGA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= ST_ROLLED_BACK, "bad status code")
	`PGA_ASSERT_NOW(a_page_zero, m_nopage, m_tdata == '0, "page set on a no-page status")
	`PGA_ASSERT_NOW(a_page_range, m_tvalid, m_tdata[PAGE_W-1:0] <= POOL_PAGES, "page past pool")

endmodule

bind page_bump_allocator_with_free_bitmap pgalloc_chk u_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the page bump allocator with its freed-page bitmap.
`timescale 1ns / 1ps
module tb_top;
	import pgalloc_pkg::*;

	// func 3 has no operation behind it; the block answers not-in-pool
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam int PHASE_ITEMS = 160;
	localparam int PHASES      = 10;
	localparam int LONG_HOLD   = 400;   // receiver hold-off, cycles
	localparam int SETTLE      = 150;   // longer than the worst rollback scan
	localparam int STUCK_LIMIT = 5000;  // cycles with no beat on either side

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [PAGE_W-1:0]    cfg_wdata;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // [12:0] count, [24:13] page_index, rest 0
	logic [FUNC_W-1:0]    s_tuser;   // [1:0] func
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // [12:0] result_page, rest 0
	logic [STAT_W-1:0]    m_tuser;   // [2:0] status

	page_bump_allocator_with_free_bitmap dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// ------------------------------------------------------------------
	// Allocator shadow: bitmap, bump pointer, page_count register
	// ------------------------------------------------------------------
	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [STAT_W-1:0] status;
	} reply_t;

	word_t       shadow_map [MAP_WORDS];
	int unsigned shadow_top;
	int unsigned shadow_pages;   // raw register value, clamped on use

	reply_t due_replies [$];     // replies owed by the block, oldest first

	int errors;
	int beats;
	int directed_beats;
	int tally [8];               // predicted replies per status code

	function automatic int unsigned usable_pages();
		return (shadow_pages > POOL_PAGES) ? POOL_PAGES : shadow_pages;
	endfunction

	function automatic void mark_freed(int unsigned p);
		if (p / WORD_BITS < MAP_WORDS)
			shadow_map[p / WORD_BITS][p % WORD_BITS] = 1'b1;
	endfunction

	// Rollback: pad the partial top word, drop all-ones words going down,
	// trim the first word with a hole and park the pointer just above it.
	function automatic int unsigned roll_back_top();
		int unsigned pc;
		int unsigned b;
		int unsigned w;
		int          k;
		int unsigned pos;
		word_t       word;
		pc = usable_pages();
		b  = (shadow_top < pc) ? shadow_top : pc;
		if (b == 0)
			return 0;
		if (b % WORD_BITS != 0) begin
			shadow_map[b / WORD_BITS] |= ~((64'd1 << (b % WORD_BITS)) - 64'd1);
			b += WORD_BITS - (b % WORD_BITS);
		end
		w = (b - 1) / WORD_BITS;
		if (w >= MAP_WORDS)
			w = MAP_WORDS - 1;
		forever begin
			word = shadow_map[w];
			if (word != '1) begin
				pos = 0;
				for (k = WORD_BITS - 1; k >= 0; k--) begin
					if (!word[k]) begin
						pos = k + 1;
						break;
					end
				end
				if (pos < WORD_BITS)
					shadow_map[w] = word & ((64'd1 << pos) - 64'd1);
				return w * WORD_BITS + pos;
			end
			shadow_map[w] = '0;
			if (w == 0)
				return 0;
			w--;
		end
	endfunction

	// One request through the shadow; updates state and returns the reply.
	function automatic reply_t compute_reply(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] cnt,
			logic [IDX_W-1:0] idx);
		reply_t      r;
		int unsigned pc;
		int unsigned lim;
		int unsigned stop;
		int unsigned i;
		pc     = usable_pages();
		r.page = '0;
		case (fn)
			FN_ALLOC: begin
				if (shadow_top <= pc && cnt <= pc - shadow_top) begin
					r.page     = PAGE_W'(shadow_top);
					shadow_top += cnt;
					r.status   = ST_GRANTED;
				end else begin
					// pool exhausted: the unused tail goes to the freed map
					for (i = shadow_top; i < pc; i++)
						mark_freed(i);
					shadow_top = pc;
					r.status   = ST_FALLBACK;
				end
			end
			FN_FREE: begin
				if (idx >= pc) begin
					r.status = ST_NOT_IN_POOL;
				end else begin
					// pages at or above the pointer are silently skipped
					lim  = (shadow_top < pc) ? shadow_top : pc;
					stop = idx + cnt;
					if (stop > lim)
						stop = lim;
					for (i = idx; i < stop; i++)
						mark_freed(i);
					r.status = ST_FREED;
				end
			end
			FN_ROLLBACK: begin
				shadow_top = roll_back_top();
				r.page     = PAGE_W'(shadow_top);
				r.status   = ST_ROLLED_BACK;
			end
			default: r.status = ST_NOT_IN_POOL;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d, want %0d (%0d left due)",
			$realtime, what, got, want, due_replies.size());
		errors++;
	endtask

	// Idle lengths: mostly none, some short, a few long.
	function automatic int random_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Receiver: checks each result beat, paces m_tready
	// ------------------------------------------------------------------
	bit steady;          // no idling on either side while set
	int hold_requests;   // bumped by the stimulus to ask for a long hold-off
	int holds_done;
	int hold_left;
	reply_t want;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_replies.size() == 0) begin
				report_mismatch("result beat with nothing due, page", m_tdata[PAGE_W-1:0], 0);
			end else begin
				want = due_replies.pop_front();
				if (m_tdata[PAGE_W-1:0] !== want.page)
					report_mismatch("result_page", m_tdata[PAGE_W-1:0], want.page);
				if (m_tuser !== want.status)
					report_mismatch("status", m_tuser, want.status);
			end
		end
		if (hold_requests != holds_done) begin
			holds_done++;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			hold_left = random_idle();
			m_tready  <= (hold_left == 0);
			if (hold_left > 0)
				hold_left--;
		end
	end

	// Watchdog: a healthy run never goes this long without a beat
	int stuck_cycles;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d results due",
				stuck_cycles, due_replies.size());
			$display("FAIL page_bump_allocator_with_free_bitmap");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one request after an optional gap; predict it once taken.
	task automatic offer_request(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] cnt,
			logic [IDX_W-1:0] idx, int gap, bit typed, logic [PAGE_W-1:0] page,
			logic [STAT_W-1:0] st);
		reply_t r;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {{(S_TDATA_W - IDX_W - PAGE_W){1'b0}}, idx, cnt};
		do @(posedge clk); while (!s_tready);
		r = compute_reply(fn, cnt, idx);
		// hand-typed rows override the shadow's answer, state still advances
		if (typed) begin
			r.page   = page;
			r.status = st;
		end
		due_replies.push_back(r);
		tally[r.status]++;
		beats++;
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_replies.size() != 0);
	endtask

	// Random request biased toward live traffic: small allocations,
	// frees just below the pointer, rollbacks; the rest is noise.
	task automatic pick_request(output logic [FUNC_W-1:0] fn, output logic [PAGE_W-1:0] cnt,
			output logic [IDX_W-1:0] idx);
		int unsigned pc;
		int unsigned b;
		int unsigned r;
		int unsigned q;
		int unsigned span;
		pc  = usable_pages();
		b   = shadow_top;
		r   = $urandom_range(0, 99);
		q   = $urandom_range(0, 99);
		cnt = PAGE_W'($urandom);
		idx = IDX_W'($urandom);
		if (r < 45) begin
			fn = FN_ALLOC;
			if (q < 80)
				cnt = PAGE_W'($urandom_range(0, 24));
			else if (q < 95)
				cnt = PAGE_W'($urandom_range(0, pc + 2));
		end else if (r < 85) begin
			fn = FN_FREE;
			if (q < 70 && b > 0) begin
				span = (b > 40) ? 40 : b - 1;
				idx  = IDX_W'(b - 1 - $urandom_range(0, span));
				cnt  = PAGE_W'($urandom_range(0, b - idx + 2));
			end
		end else if (r < 97) begin
			fn = FN_ROLLBACK;
		end else begin
			fn = FN_UNUSED;
		end
	endtask

	// Directed plan: one row per request, reply typed where obvious
	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [PAGE_W-1:0] cnt;
		logic [IDX_W-1:0]  idx;
		logic              typed;
		logic [PAGE_W-1:0] page;
		logic [STAT_W-1:0] st;
	} plan_row_t;

	plan_row_t plan [$];

	task automatic add_row(logic [FUNC_W-1:0] fn, int cnt, int idx, bit typed, int page,
			logic [STAT_W-1:0] st);
		plan_row_t row;
		row = '{fn: fn, cnt: PAGE_W'(cnt), idx: IDX_W'(idx), typed: typed,
			page: PAGE_W'(page), st: st};
		plan.push_back(row);
	endtask

	initial begin : stimulus
		int                ph;
		int                n;
		int                gap;
		int unsigned       setting;
		logic [FUNC_W-1:0] fn;
		logic [PAGE_W-1:0] cnt;
		logic [IDX_W-1:0]  idx;

		// all inputs known from time zero, shadow in its reset state
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = FN_ALLOC;
		m_tready      = 1'b0;
		steady        = 1'b0;
		hold_requests = 0;
		holds_done    = 0;
		hold_left     = 0;
		stuck_cycles  = 0;
		errors        = 0;
		beats         = 0;
		foreach (tally[i])
			tally[i] = 0;
		foreach (shadow_map[i])
			shadow_map[i] = '0;
		shadow_top   = 0;
		shadow_pages = POOL_PAGES;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset page_count of 4096 ---
		add_row(FN_ROLLBACK,    0,    0, 1,    0, ST_ROLLED_BACK); // empty pool
		add_row(FN_ALLOC,       0,    0, 1,    0, ST_GRANTED);     // zero count
		add_row(FN_ALLOC,       1,    0, 1,    0, ST_GRANTED);
		add_row(FN_ALLOC,      63,    0, 1,    1, ST_GRANTED);     // top = 64
		add_row(FN_FREE,        1, 4095, 1,    0, ST_FREED);       // above pointer
		add_row(FN_UNUSED,   8191, 4095, 1,    0, ST_NOT_IN_POOL); // unknown func
		add_row(FN_FREE,       32,   32, 1,    0, ST_FREED);
		add_row(FN_ROLLBACK,    0,    0, 1,   32, ST_ROLLED_BACK); // trims upper half
		add_row(FN_FREE,        0,    0, 1,    0, ST_FREED);       // zero-length free
		add_row(FN_ALLOC,    4064,    0, 1,   32, ST_GRANTED);     // exact fit
		add_row(FN_ALLOC,       0,    0, 1, 4096, ST_GRANTED);     // zero at full pool
		add_row(FN_ALLOC,       1,    0, 1,    0, ST_FALLBACK);
		add_row(FN_FREE,     4096,    0, 1,    0, ST_FREED);       // whole pool
		add_row(FN_ROLLBACK,    0,    0, 1,    0, ST_ROLLED_BACK); // every word full
		add_row(FN_ALLOC,    8191,    0, 1,    0, ST_FALLBACK);    // largest count
		add_row(FN_ROLLBACK, 8191, 4095, 1,    0, ST_ROLLED_BACK);
		add_row(FN_ALLOC,     100,    0, 1,    0, ST_GRANTED);
		add_row(FN_FREE,     8191,   10, 1,    0, ST_FREED);       // clipped at pointer
		add_row(FN_ROLLBACK,    0,    0, 0,    0, ST_ROLLED_BACK); // pads partial word
		add_row(FN_ALLOC,    4096,    0, 0,    0, ST_FALLBACK);    // tail into map
		add_row(FN_FREE,        1, 4095, 1,    0, ST_FREED);       // last page
		add_row(FN_ROLLBACK,    0,    0, 0,    0, ST_ROLLED_BACK); // long downward scan
		add_row(FN_ALLOC,       5,    0, 0,    0, ST_GRANTED);
		foreach (plan[i])
			offer_request(plan[i].fn, plan[i].cnt, plan[i].idx, random_idle(),
				plan[i].typed, plan[i].page, plan[i].st);
		directed_beats = beats;

		// --- random phases, one page_count setting each ---
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       setting = POOL_PAGES;
				1:       setting = 0;
				2:       setting = 8191;                     // clamps to the pool
				3:       setting = 1;
				4:       setting = WORD_BITS;
				5:       setting = WORD_BITS + 1;
				6:       setting = POOL_PAGES - 1;
				7:       setting = $urandom_range(2, POOL_PAGES - 1);
				8:       setting = $urandom_range(0, 8191);
				default: setting = POOL_PAGES;
			endcase

			// register changes only with the block idle
			drain_replies();
			cfg_we       <= 1'b1;
			cfg_wdata    <= PAGE_W'(setting);
			@(posedge clk);
			cfg_we       <= 1'b0;
			shadow_pages = setting;

			steady = (ph == 0);
			// long receiver hold-off while requests keep coming back to back
			if (ph == 2)
				hold_requests++;

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// sender pauses mid-phase until the pipe is empty
				if (ph == 5 && n == PHASE_ITEMS / 2)
					drain_replies();
				pick_request(fn, cnt, idx);
				gap = (steady || (ph == 2 && n < 30)) ? 0 : random_idle();
				offer_request(fn, cnt, idx, gap, 1'b0, '0, ST_GRANTED);
			end
		end
		steady = 1'b0;

		// let any stray result surface before the verdict
		drain_replies();
		repeat (SETTLE) @(posedge clk);

		$display("%0d request beats (%0d directed), %0d page-count settings from 0 to 8191",
			beats, directed_beats, PHASES);
		$display("replies: %0d granted, %0d fallback, %0d freed, %0d not in pool, %0d rolled back",
			tally[ST_GRANTED], tally[ST_FALLBACK], tally[ST_FREED], tally[ST_NOT_IN_POOL],
			tally[ST_ROLLED_BACK]);
		if (errors == 0 && due_replies.size() == 0)
			$display("PASS page_bump_allocator_with_free_bitmap");
		else
			$display("FAIL page_bump_allocator_with_free_bitmap");
		$finish;
	end

endmodule
